// File: hdl/npt_pkg.sv
package npt_pkg;

	localparam int DIGEST_BYTES  = 20;
	localparam int CARRIED_BYTES = 32;
	localparam int ROUNDS        = 80;

	localparam logic [2:0] REG_SCRAMBLE_HIGH   = 3'd0;
	localparam logic [2:0] REG_SCRAMBLE_MIDDLE = 3'd1;
	localparam logic [2:0] REG_SCRAMBLE_LOW    = 3'd2;
	localparam logic [2:0] REG_TARGET_HIGH     = 3'd3;
	localparam logic [2:0] REG_TARGET_MIDDLE   = 3'd4;
	localparam logic [2:0] REG_TARGET_LOW      = 3'd5;

	typedef struct packed {
		logic [63:0] pass_word0;
		logic [63:0] pass_word1;
		logic [63:0] pass_word2;
		logic [63:0] pass_word3;
		logic [5:0]  pass_length;
		logic        batch_end;
	} npt_in_t;

	typedef struct packed {
		logic [63:0] token_high;
		logic [63:0] token_middle;
		logic [31:0] token_low;
		logic        match;
		logic        batch_done;
	} npt_out_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} sha_st_t;

	typedef logic [15:0][31:0] sha_wnd_t;

	localparam sha_st_t SHA_IV = '{
		a: 32'h67452301, b: 32'hEFCDAB89, c: 32'h98BADCFE,
		d: 32'h10325476, e: 32'hC3D2E1F0
	};

	function automatic logic [31:0] sha_k(int r);
		if (r < 20) return 32'h5A827999;
		else if (r < 40) return 32'h6ED9EBA1;
		else if (r < 60) return 32'h8F1BBCDC;
		else return 32'hCA62C1D6;
	endfunction

	function automatic logic [31:0] sha_f(int r, logic [31:0] b, logic [31:0] c,
			logic [31:0] d);
		if (r < 20) return (b & c) | (~b & d);
		else if (r < 40) return b ^ c ^ d;
		else if (r < 60) return (b & c) | (b & d) | (c & d);
		else return b ^ c ^ d;
	endfunction

endpackage

// File: hdl/native_password_token.sv
// Password scramble token pipeline: each request carries a password of up to
// 32 bytes and yields SHA1(pw) XOR SHA1(scramble || SHA1(SHA1(pw))) with a
// target match flag. Three fully unrolled SHA-1 units of 80 round stages plus
// a digest add stage each, an input register and an output register make up
// the pipeline; one request is accepted every cycle unless the output is
// stalled. Write the scramble and target only while idle.
module native_password_token import npt_pkg::*; #(
	parameter int MAX_PASS_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  npt_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output npt_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int LIMIT = (MAX_PASS_BYTES < CARRIED_BYTES) ? MAX_PASS_BYTES : CARRIED_BYTES;
	localparam logic [5:0] LIMIT6 = 6'(LIMIT);

	logic [63:0] scr_hi_q, scr_mid_q, tgt_hi_q, tgt_mid_q;
	logic [31:0] scr_lo_q, tgt_lo_q;

	logic         en;
	logic [5:0]   len;
	logic [255:0] pw;
	logic [511:0] blk;
	logic         v_s0;
	logic [511:0] blk_s0;
	logic         bat_s0;

	logic         v1;
	logic [159:0] s1;
	logic         b1;
	logic         v2;
	logic [159:0] s2;
	logic [160:0] sd2;
	logic         v3;
	logic [159:0] t3;
	logic [160:0] sd3;
	logic [159:0] tok;

	assign cfg_ready = 1'b1;
	assign en        = !out_valid || !out_stall;
	assign in_stall  = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_hi_q  <= '0;
			scr_mid_q <= '0;
			scr_lo_q  <= '0;
			tgt_hi_q  <= '0;
			tgt_mid_q <= '0;
			tgt_lo_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCRAMBLE_HIGH:   scr_hi_q  <= cfg_data;
				REG_SCRAMBLE_MIDDLE: scr_mid_q <= cfg_data;
				REG_SCRAMBLE_LOW:    scr_lo_q  <= cfg_data[31:0];
				REG_TARGET_HIGH:     tgt_hi_q  <= cfg_data;
				REG_TARGET_MIDDLE:   tgt_mid_q <= cfg_data;
				REG_TARGET_LOW:      tgt_lo_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign len = (in_data.pass_length > LIMIT6) ? LIMIT6 : in_data.pass_length;
	assign pw  = {in_data.pass_word0, in_data.pass_word1, in_data.pass_word2,
		in_data.pass_word3};

	always_comb begin
		blk = '0;
		for (int j = 0; j < CARRIED_BYTES; j++) begin
			if (7'(j) < {1'b0, len}) blk[511-8*j -: 8] = pw[255-8*j -: 8];
		end
		blk[511-8*len -: 8] = 8'h80;
		blk[63:0] = {55'd0, len, 3'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blk_s0 <= blk;
			bat_s0 <= in_data.batch_end;
		end
	end

	npt_sha1 #(.SW(1)) u_pass1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(v_s0), .blk(blk_s0), .sd_in(bat_s0),
		.vld_out(v1), .digest(s1), .sd_out(b1)
	);

	npt_sha1 #(.SW(161)) u_pass2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(v1), .blk({s1, 8'h80, 280'd0, 64'd160}), .sd_in({s1, b1}),
		.vld_out(v2), .digest(s2), .sd_out(sd2)
	);

	npt_sha1 #(.SW(161)) u_pass3 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(v2),
		.blk({scr_hi_q, scr_mid_q, scr_lo_q, s2, 8'h80, 120'd0, 64'd320}),
		.sd_in(sd2),
		.vld_out(v3), .digest(t3), .sd_out(sd3)
	);

	assign tok = sd3[160:1] ^ t3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.token_high   <= tok[159:96];
			out_data.token_middle <= tok[95:32];
			out_data.token_low    <= tok[31:0];
			out_data.match        <= (tok == {tgt_hi_q, tgt_mid_q, tgt_lo_q});
			out_data.batch_done   <= sd3[0];
		end
	end

endmodule

// File: hdl/npt_round.sv
module npt_round import npt_pkg::*; #(
	parameter int RND = 0,
	parameter int SW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  sha_st_t       st_in,
	input  sha_wnd_t      wnd_in,
	input  logic [SW-1:0] sd_in,
	output logic          vld_out,
	output sha_st_t       st_out,
	output sha_wnd_t      wnd_out,
	output logic [SW-1:0] sd_out
);

	logic [31:0] tmp;
	logic [31:0] wnew;

	assign tmp = {st_in.a[26:0], st_in.a[31:27]} + sha_f(RND, st_in.b, st_in.c, st_in.d)
		+ st_in.e + sha_k(RND) + wnd_in[15];
	assign wnew = {wnd_in[2][30:0] ^ wnd_in[7][30:0] ^ wnd_in[13][30:0] ^ wnd_in[15][30:0],
		wnd_in[2][31] ^ wnd_in[7][31] ^ wnd_in[13][31] ^ wnd_in[15][31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_out.a <= tmp;
			st_out.b <= st_in.a;
			st_out.c <= {st_in.b[1:0], st_in.b[31:2]};
			st_out.d <= st_in.c;
			st_out.e <= st_in.d;
			wnd_out  <= {wnd_in[14:0], wnew};
			sd_out   <= sd_in;
		end
	end

endmodule

// File: hdl/npt_sha1.sv
module npt_sha1 import npt_pkg::*; #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [511:0]  blk,
	input  logic [SW-1:0] sd_in,
	output logic          vld_out,
	output logic [159:0]  digest,
	output logic [SW-1:0] sd_out
);

	logic          vld_s [0:ROUNDS];
	sha_st_t       st_s  [0:ROUNDS];
	sha_wnd_t      wnd_s [0:ROUNDS];
	logic [SW-1:0] sd_s  [0:ROUNDS];

	assign vld_s[0] = vld_in;
	assign st_s[0]  = SHA_IV;
	assign wnd_s[0] = sha_wnd_t'(blk);
	assign sd_s[0]  = sd_in;

	for (genvar r = 0; r < ROUNDS; r++) begin : g_rnd
		npt_round #(.RND(r), .SW(SW)) u_rnd (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld_s[r]), .st_in(st_s[r]), .wnd_in(wnd_s[r]), .sd_in(sd_s[r]),
			.vld_out(vld_s[r+1]), .st_out(st_s[r+1]), .wnd_out(wnd_s[r+1]),
			.sd_out(sd_s[r+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_s[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			digest <= {st_s[ROUNDS].a + SHA_IV.a, st_s[ROUNDS].b + SHA_IV.b,
				st_s[ROUNDS].c + SHA_IV.c, st_s[ROUNDS].d + SHA_IV.d,
				st_s[ROUNDS].e + SHA_IV.e};
			sd_out <= sd_s[ROUNDS];
		end
	end

endmodule
